>>> src/ttm_pkg.sv
// Shared types and constants for the token tree mutex block.
`default_nettype none

package ttm_pkg;

  // Width of a node id on the ports.
  localparam int ID_W = 4;

  // Most results one request may give, and the width of the hand-over count.
  localparam int MAX_RESULTS = 16;
  localparam int KW = $clog2(MAX_RESULTS);

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_ID = 2'd1;
  localparam logic [1:0] ST_FAULT  = 2'd2;

  // Class of a queued word, settled by the front part.
  typedef enum logic [1:0] {
    K_SET,
    K_REQ,
    K_BAD
  } kind_t;

  // One-slot queue between the front and the back.
  typedef struct packed {
    logic            valid;
    kind_t           kind;
    logic [ID_W-1:0] node;
    logic [ID_W-1:0] parent;
  } slot_t;

  // Sequencer states of the back part.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RECORD,
    S_LOOK,
    S_MOVE1,
    S_MOVE2,
    S_ERR
  } state_t;

endpackage

`default_nettype wire

>>> src/ttm_front.sv
// Front part: accepts input words, classifies them and holds them in a one-slot queue.
`default_nettype none

module ttm_front import ttm_pkg::*; #(
  parameter int NODES = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire logic            req_type,
  input  wire logic [ID_W-1:0] node,
  input  wire logic [ID_W-1:0] parent_node,
  input  wire logic            pop,
  output slot_t                slot
);

  logic  take;
  logic  bad_id;
  kind_t kind;

  // Hold the slot until the back part takes it.
  assign item_stall = slot.valid && !pop;
  assign take       = item_valid && !item_stall;

  assign bad_id = (32'(node) >= NODES) || (!req_type && (32'(parent_node) >= NODES));

  always_comb begin
    if (bad_id) begin
      kind = K_BAD;
    end else if (req_type) begin
      kind = K_REQ;
    end else begin
      kind = K_SET;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      slot.kind   <= kind;
      slot.node   <= node;
      slot.parent <= parent_node;
    end
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (take) begin
      slot.valid <= 1'b1;
    end else if (pop) begin
      slot.valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/ttm_back.sv
// Back part: tree state, climb and hand-over sequencer, and the result register.
`default_nettype none

module ttm_back import ttm_pkg::*; #(
  parameter int NODES = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire slot_t           slot,
  output logic                 pop,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output logic [ID_W-1:0]      holder,
  output logic                 last,
  output logic [1:0]           status
);

  localparam int NW = $clog2(NODES);
  localparam int SW = $clog2(NODES + 1);

  state_t state, state_next;

  // Parent pointers and pending child links live in memories; the per-node
  // flags sit in flip-flops so that reset clears them at once.
  logic [NW-1:0]    parent_mem [NODES];
  logic [NW-1:0]    pend_mem   [NODES];
  logic [NODES-1:0] parent_ok;
  logic [NODES-1:0] pend_ok;
  logic [NODES-1:0] tok;

  logic [NW-1:0] par_q;
  logic          par_ok_q;
  logic [NW-1:0] pc_q;

  logic [NW-1:0] cur;
  logic [NW-1:0] req_node;
  logic [NW-1:0] root;
  logic [NW-1:0] scan_idx;
  logic [SW-1:0] steps;
  logic [KW-1:0] hops;
  logic          climb_done;
  logic          scan_done;
  logic          found;
  logic          bad;
  logic [1:0]    err_code;

  logic [NW-1:0] eff_par;
  logic [NW-1:0] slot_nd;
  logic [NW-1:0] slot_pn;
  logic          out_free;
  logic          both_done;
  logic          more;

  logic          p_we;
  logic [NW-1:0] p_waddr;
  logic [NW-1:0] p_wdata;
  logic [NW-1:0] p_raddr;
  logic          c_we;
  logic [NW-1:0] c_waddr;
  logic [NW-1:0] c_wdata;
  logic          pend_clr_en;
  logic [NW-1:0] pend_clr_idx;
  logic          tok_set_en;
  logic [NW-1:0] tok_set_idx;
  logic          tok_clr_en;
  logic [NW-1:0] tok_clr_idx;
  logic          emit;
  logic [NW-1:0] emit_holder;
  logic          emit_last;
  logic [1:0]    emit_status;

  // An entry never written reads as parent zero.
  assign eff_par   = par_ok_q ? par_q : '0;
  assign slot_nd   = NW'(slot.node);
  assign slot_pn   = NW'(slot.parent);
  assign out_free  = !result_valid || !result_stall;
  assign both_done = climb_done && scan_done;
  assign more      = pend_ok[root] && (hops != KW'(MAX_RESULTS - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (slot.valid) begin
          case (slot.kind)
            K_REQ:   state_next = S_CHECK;
            K_BAD:   state_next = S_ERR;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CHECK: begin
        if (both_done) begin
          state_next = (bad || !found) ? S_ERR : S_RECORD;
        end
      end
      S_RECORD: begin
        if (eff_par == cur) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          state_next = more ? S_MOVE1 : S_IDLE;
        end
      end
      S_MOVE1: state_next = S_MOVE2;
      S_MOVE2: state_next = S_LOOK;
      S_ERR: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Strobes for the stores and the result register.
  always_comb begin
    pop          = 1'b0;
    p_we         = 1'b0;
    p_waddr      = '0;
    p_wdata      = '0;
    p_raddr      = eff_par;
    c_we         = 1'b0;
    c_waddr      = eff_par;
    c_wdata      = cur;
    pend_clr_en  = 1'b0;
    pend_clr_idx = '0;
    tok_set_en   = 1'b0;
    tok_set_idx  = '0;
    tok_clr_en   = 1'b0;
    tok_clr_idx  = '0;
    emit         = 1'b0;
    emit_holder  = '0;
    emit_last    = 1'b1;
    emit_status  = ST_OK;
    case (state)
      S_IDLE: begin
        pop     = slot.valid;
        p_raddr = slot_nd;
        if (slot.valid && (slot.kind == K_SET)) begin
          p_we         = 1'b1;
          p_waddr      = slot_nd;
          p_wdata      = slot_pn;
          pend_clr_en  = 1'b1;
          pend_clr_idx = slot_nd;
          if (slot.node == slot.parent) begin
            tok_set_en  = 1'b1;
            tok_set_idx = slot_nd;
          end else begin
            tok_clr_en  = 1'b1;
            tok_clr_idx = slot_nd;
          end
        end
      end
      S_CHECK: begin
        if (both_done) begin
          p_raddr = req_node;
        end
      end
      S_RECORD: begin
        c_we = (eff_par != cur);
      end
      S_LOOK: begin
        emit        = out_free;
        emit_holder = root;
        emit_last   = !more;
        emit_status = (pend_ok[root] && !more) ? ST_FAULT : ST_OK;
      end
      S_MOVE1: begin
        p_we         = 1'b1;
        p_waddr      = root;
        p_wdata      = pc_q;
        pend_clr_en  = 1'b1;
        pend_clr_idx = root;
        tok_clr_en   = 1'b1;
        tok_clr_idx  = root;
        tok_set_en   = 1'b1;
        tok_set_idx  = pc_q;
      end
      S_MOVE2: begin
        p_we    = 1'b1;
        p_waddr = pc_q;
        p_wdata = pc_q;
      end
      S_ERR: begin
        emit        = out_free;
        emit_status = err_code;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-node flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      parent_ok <= '0;
      pend_ok   <= '0;
      tok       <= NODES'(1);
    end else begin
      if (p_we) begin
        parent_ok[p_waddr] <= 1'b1;
      end
      if (c_we) begin
        pend_ok[c_waddr] <= 1'b1;
      end
      if (pend_clr_en) begin
        pend_ok[pend_clr_idx] <= 1'b0;
      end
      if (tok_clr_en) begin
        tok[tok_clr_idx] <= 1'b0;
      end
      if (tok_set_en) begin
        tok[tok_set_idx] <= 1'b1;
      end
    end
  end

  // Parent memory, one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    par_q    <= parent_mem[p_raddr];
    par_ok_q <= parent_ok[p_raddr];
  end

  // Pending child memory, read at the current holder.
  always_ff @(posedge clk) begin
    if (c_we) begin
      pend_mem[c_waddr] <= c_wdata;
    end
    pc_q <= pend_mem[root];
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop) begin
          cur        <= slot_nd;
          req_node   <= slot_nd;
          steps      <= '0;
          climb_done <= 1'b0;
          bad        <= 1'b0;
          scan_idx   <= '0;
          scan_done  <= 1'b0;
          found      <= 1'b0;
          hops       <= '0;
          err_code   <= ST_BAD_ID;
        end
      end
      S_CHECK: begin
        if (!climb_done) begin
          if (eff_par == cur) begin
            climb_done <= 1'b1;
          end else if (steps == SW'(NODES)) begin
            climb_done <= 1'b1;
            bad        <= 1'b1;
          end else begin
            cur   <= eff_par;
            steps <= steps + SW'(1);
          end
        end
        if (!scan_done) begin
          if (tok[scan_idx]) begin
            found     <= 1'b1;
            root      <= scan_idx;
            scan_done <= 1'b1;
          end else if (scan_idx == NW'(NODES - 1)) begin
            scan_done <= 1'b1;
          end else begin
            scan_idx <= scan_idx + NW'(1);
          end
        end
        if (both_done) begin
          cur      <= req_node;
          err_code <= ST_FAULT;
        end
      end
      S_RECORD: begin
        if (eff_par != cur) begin
          cur <= eff_par;
        end
      end
      S_MOVE2: begin
        root <= pc_q;
        hops <= hops + KW'(1);
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      holder <= ID_W'(emit_holder);
      last   <= emit_last;
      status <= emit_status;
    end
  end

endmodule

`default_nettype wire

>>> src/tree_token_mutex_path_reversal.sv
// Top level of the token tree mutex with path reversal.
//
//   channel  | handshake                  | word
//   ---------+----------------------------+--------------------------------
//   item     | item_valid / item_stall    | req_type, node, parent_node
//   result   | result_valid / result_stall| holder, last, status
//
// A set word is handled in the back part's idle state and gives no result. A bad
// id goes from the queue slot to the error state, which loads its error word.
// A request climbs the parent memory one link a cycle while the token flags are
// scanned alongside, climbs again to record child links, then passes through
// the look and two move states on each hand-over, and the look state once more
// for the final holder; the look state waits while the result is stalled.
// Reset clears the token, parent and link flags at once: node 0 holds the
// token and every node reads as a child of node 0.
// A stalled result holds; the front keeps taking one word ahead meanwhile.
`default_nettype none

module tree_token_mutex_path_reversal import ttm_pkg::*; #(
  parameter int NODES = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire logic            req_type,
  input  wire logic [ID_W-1:0] node,
  input  wire logic [ID_W-1:0] parent_node,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output logic [ID_W-1:0]      holder,
  output logic                 last,
  output logic [1:0]           status
);

  // Queue slot from the front, and the back part's take strobe.
  slot_t slot;
  logic  pop;

  // Classify and queue.
  ttm_front #(
    .NODES(NODES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .req_type   (req_type),
    .node       (node),
    .parent_node(parent_node),
    .pop        (pop),
    .slot       (slot)
  );

  // Walk the tree, pass the token and drive results.
  ttm_back #(
    .NODES(NODES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .slot        (slot),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .holder      (holder),
    .last        (last),
    .status      (status)
  );

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for the token tree mutex block: directed and random words against a local tree model.
`timescale 1ns / 100ps

module tb;
  import ttm_pkg::*;

  localparam int NODES = 16;
  localparam int RANDOM_WORDS = 500;
  // Quiet cycles allowed before the run is called hung. A request walks the
  // tree twice and passes through the look and move states on each hand-over,
  // and result stalls lengthen it; take it many times over.
  localparam int IDLE_LIMIT = 3000;
  // Cycles let pass after the last owed result, to catch stray words.
  localparam int DRAIN_CYCLES = 150;

  // Word kinds on the item channel.
  localparam logic REQ_SET = 1'b0;
  localparam logic REQ_CS  = 1'b1;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BEAT
  } stall_mode_t;

  typedef struct packed {
    logic [ID_W-1:0] holder;
    logic            last;
    logic [1:0]      status;
  } grant_t;

  logic            clk;
  logic            rst = 1'b1;
  logic            item_valid = 1'b0;
  logic            item_stall;
  logic            req_type = 1'b0;
  logic [ID_W-1:0] node = '0;
  logic [ID_W-1:0] parent_node = '0;
  logic            result_valid;
  logic            result_stall = 1'b0;
  logic [ID_W-1:0] holder;
  logic            last;
  logic [1:0]      status;

  tree_token_mutex_path_reversal #(.NODES(NODES)) DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .req_type    (req_type),
    .node        (node),
    .parent_node (parent_node),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .holder      (holder),
    .last        (last),
    .status      (status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tree model: parent pointers, token flags and the child links left behind
  // by each climb. Updated as each word is accepted.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0] up_link    [NODES];
  logic            owns_token [NODES];
  logic [ID_W-1:0] link_child [NODES];
  logic            link_set   [NODES];

  grant_t grants_owed[$];
  int     errors = 0;
  int     words_sent = 0;
  int     burst_left = 0;

  initial begin
    for (int i = 0; i < NODES; i++) begin
      up_link[i]    = '0;
      owns_token[i] = (i == 0);
      link_child[i] = '0;
      link_set[i]   = 1'b0;
    end
  end

  function automatic void owe(input logic [ID_W-1:0] h, input logic fin, input logic [1:0] st);
    grant_t g;
    g.holder = h;
    g.last   = fin;
    g.status = st;
    grants_owed.push_back(g);
  endfunction

  // Work out the results of one accepted word and advance the tree.
  function automatic void predict_grants(input logic t, input logic [ID_W-1:0] n,
                                         input logic [ID_W-1:0] p);
    logic [ID_W-1:0] x;
    logic [ID_W-1:0] nxt;
    logic [ID_W-1:0] top;
    int              steps;
    int              hops;
    bit              found;
    if (t == REQ_SET) begin
      if (n >= NODES || p >= NODES) begin
        owe('0, 1'b1, ST_BAD_ID);
        return;
      end
      // Setting a node drops its own child link; it holds the token only as a root.
      up_link[n]    = p;
      link_set[n]   = 1'b0;
      link_child[n] = '0;
      owns_token[n] = (p == n);
      return;
    end
    if (n >= NODES) begin
      owe('0, 1'b1, ST_BAD_ID);
      return;
    end
    // Climb once without writing: a climb that never meets a root is a cycle.
    x = n;
    steps = 0;
    while (up_link[x] != x) begin
      if (steps >= NODES) begin
        owe('0, 1'b1, ST_FAULT);
        return;
      end
      x = up_link[x];
      steps++;
    end
    // The lowest-numbered holder serves, whether or not it is on the path.
    found = 1'b0;
    top = '0;
    for (int i = 0; i < NODES; i++) begin
      if (!found && owns_token[i]) begin
        top = ID_W'(i);
        found = 1'b1;
      end
    end
    if (!found) begin
      owe('0, 1'b1, ST_FAULT);
      return;
    end
    // Climb again, leaving a child link in each parent.
    x = n;
    while (up_link[x] != x) begin
      nxt = up_link[x];
      link_child[nxt] = x;
      link_set[nxt] = 1'b1;
      x = nxt;
    end
    // Follow the links, reversing each pointer crossed; stale links count too.
    hops = 0;
    while (link_set[top]) begin
      if (hops >= MAX_RESULTS - 1) begin
        owe(top, 1'b1, ST_FAULT);
        return;
      end
      owe(top, 1'b0, ST_OK);
      hops++;
      nxt = link_child[top];
      link_set[top]   = 1'b0;
      link_child[top] = '0;
      owns_token[top] = 1'b0;
      up_link[top]    = nxt;
      up_link[nxt]    = nxt;
      owns_token[nxt] = 1'b1;
      top = nxt;
    end
    owe(top, 1'b1, ST_OK);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps; hold each word until taken.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic t, input logic [ID_W-1:0] n, input logic [ID_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid  <= 1'b1;
    req_type    <= t;
    node        <= n;
    parent_node <= p;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_grants(t, n, p);
    words_sent++;
  endtask

  // Set every node: a random tree, or a single line when as_line is high.
  // Hand back the node at the far end of the order, the deepest one on a line.
  task automatic build_tree(input bit as_line, output logic [ID_W-1:0] deepest);
    logic [ID_W-1:0] order [NODES];
    logic [ID_W-1:0] tmp;
    logic [ID_W-1:0] p;
    int              j;
    for (int i = 0; i < NODES; i++) order[i] = ID_W'(i);
    for (int i = NODES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    send_word(REQ_SET, order[0], order[0]);
    for (int i = 1; i < NODES; i++) begin
      if (as_line) p = order[i-1];
      else if ($urandom_range(0, 15) == 0) p = order[i];   // a second root now and then
      else p = order[$urandom_range(0, i - 1)];
      send_word(REQ_SET, order[i], p);
    end
    deepest = order[NODES-1];
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // From reset: a lone root, a hand-over to the far id, a second root that
  // serves a request off its own tree, and stale links followed later on.
  task automatic test_roots_and_links();
    send_word(REQ_CS,  4'd0,  4'd15);
    send_word(REQ_CS,  4'd15, 4'd0);
    send_word(REQ_SET, 4'd3,  4'd3);
    send_word(REQ_CS,  4'd7,  4'd15);
    send_word(REQ_SET, 4'd3,  4'd15);
    send_word(REQ_CS,  4'd3,  4'd0);
    send_word(REQ_CS,  4'd0,  4'd0);
  endtask

  // Two nodes pointing at each other: a climb through them never ends.
  task automatic test_cycle();
    send_word(REQ_SET, 4'd1, 4'd2);
    send_word(REQ_SET, 4'd2, 4'd1);
    send_word(REQ_CS,  4'd1, 4'd9);
  endtask

  // A line through all nodes and a request from its foot: the longest chain.
  task automatic test_long_chain();
    logic [ID_W-1:0] foot;
    build_tree(1'b1, foot);
    send_word(REQ_CS, foot, 4'd6);
  endtask

  // Mostly requests on rebuilt trees, with stray sets that add roots or cycles.
  task automatic test_random();
    int              stop_at;
    int              pick;
    logic [ID_W-1:0] foot;
    logic [ID_W-1:0] n;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      n = ID_W'($urandom_range(0, NODES - 1));
      if (pick < 2) begin
        build_tree(pick == 1, foot);
        if (pick == 1) send_word(REQ_CS, foot, ID_W'($urandom));
      end else if (pick < 5) begin
        send_word(REQ_SET, n, ID_W'($urandom));
      end else if (pick < 7) begin
        send_word(REQ_SET, n, n);
      end else begin
        send_word(REQ_CS, n, ID_W'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall: switch between patterns every so often, including
  // stretches with no stall at all.
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          beat = 0;

  always @(posedge clk) begin
    beat <= beat + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(30, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  result_stall <= 1'b0;
      STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
      STALL_BEAT:  result_stall <= ((beat % 7) < 3);
      default:     result_stall <= 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result check: compare each taken word with the oldest owed one.
  // ---------------------------------------------------------------------------
  grant_t want;

  function automatic void check_field(input string what, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (grants_owed.size() == 0) begin
        $display("%0t: result word with none owed, actual holder %0d last %0d status %0d",
                 $time, holder, last, status);
        errors++;
      end else begin
        want = grants_owed.pop_front();
        check_field("holder", want.holder, holder);
        check_field("last",   want.last,   last);
        check_field("status", want.status, status);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: give up when neither channel moves a word for too long.
  // ---------------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no handshake for %0d cycles, %0d results owed",
               $time, quiet, grants_owed.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests, drain and report.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_roots_and_links();
    test_cycle();
    test_long_chain();
    test_random();
    item_valid <= 1'b0;
    while (grants_owed.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/ttm_pkg.sv
src/ttm_front.sv
src/ttm_back.sv
src/tree_token_mutex_path_reversal.sv
dv/tb.sv
